@@ rtl/core/neuron_rprop_backprop_trainer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the neuron trainer
// Shared concurrent assertion forms, all clocked on aclk and reset by aresetn.
// ----------------------------------------------------------------------------
`ifndef NEURON_RPROP_BACKPROP_TRAINER_ASSERT_SVH
`define NEURON_RPROP_BACKPROP_TRAINER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NRBT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NRBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/nrbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neuron trainer package
// Types, codes and Q8.24 and Q16.48 saturation helpers used across the trainer.
// ----------------------------------------------------------------------------
package nrbt_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_FWD   = 2'd1;
    localparam logic [1:0] CMD_LEARN = 2'd2;

    localparam logic KIND_SUM   = 1'b0;
    localparam logic KIND_LEARN = 1'b1;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_LR    = 3'd1;
    localparam logic [2:0] CFG_MOM   = 3'd2;
    localparam logic [2:0] CFG_ETP   = 3'd3;
    localparam logic [2:0] CFG_ETM   = 3'd4;
    localparam logic [2:0] CFG_SMIN  = 3'd5;
    localparam logic [2:0] CFG_SMAX  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_FACC,
        S_FBIAS,
        S_FSUM,
        S_L1,
        S_L2,
        S_L3,
        S_L4,
        S_L5,
        S_OUT
    } state_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        if (x[32] != x[31]) begin
            return x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] sat41(input logic signed [40:0] x);
        if (x[40:31] != {10{x[40]}}) begin
            return x[40] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return x[31:0];
    endfunction

    // Round a Q16.48 product to nearest Q8.24 (half up) and saturate.
    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [64:0] r;
        r = {p[63], p} + 65'sd8388608;
        return sat41(r[64:24]);
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
        end
        return s[63:0];
    endfunction

endpackage

@@ rtl/core/nrbt_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// One signed 32 by 32 multiplication per cycle with a registered product.
// ----------------------------------------------------------------------------
module nrbt_mul (
    input  logic               aclk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

@@ rtl/core/neuron_rprop_backprop_trainer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single neuron Rprop / momentum trainer
// Weight table with bias entry, forward accumulation and per-entry learning.
// ----------------------------------------------------------------------------
// The input channel (s_*) carries one command per transaction: load a weight,
// present one forward element, or learn one entry. The result channel (m_*)
// carries a forward sum (on the element marked last) or a learn result.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata; the
// user must write them while the block is idle; the block does not enforce it.
// A load is written to the weight table from the idle state. A forward element
// passes through the read and accumulate states; the last one then adds the
// bias entry and forms the sum before its result is presented from the output
// state. A learn transaction passes from the read state through the learn
// states to the output state: up to four products pass one after another
// through the single shared 32x32 multiplier, after one weight memory read.
// One item is in work at a time; the result register lets the next item be
// accepted while an earlier result still waits on m_ready. A stalled receiver
// holds the block in its output state only when a second result is ready.
// Reset returns the configuration registers to their defaults, clears the
// accumulator and marks every step size and last gradient as zero; weights
// are undefined until loaded.
// ----------------------------------------------------------------------------
module neuron_rprop_backprop_trainer #(
    parameter int MAX_INPUTS = 64
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [1:0]                                s_cmd,
    input  logic [$clog2(MAX_INPUTS+1)-1:0]           s_entry,
    input  logic signed [31:0]                        s_value,
    input  logic signed [31:0]                        s_grad_in,
    input  logic                                      s_last,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic                                      m_kind,
    output logic signed [31:0]                        m_sum_out,
    output logic signed [31:0]                        m_new_weight,
    output logic signed [31:0]                        m_error_term,
    input  logic                                      cfg_we,
    input  logic [2:0]                                cfg_addr,
    input  logic [30:0]                               cfg_wdata
);

    import nrbt_pkg::*;

    `include "neuron_rprop_backprop_trainer_assert.svh"

    localparam int DEPTH   = MAX_INPUTS + 1;
    localparam int ENTRY_W = $clog2(DEPTH);
    localparam logic [ENTRY_W-1:0] BIAS_IDX = ENTRY_W'(MAX_INPUTS);

    // Control state
    state_t state_reg, state_next;
    logic   m_valid_reg;
    logic signed [63:0] acc_reg;
    logic [DEPTH-1:0]   sgv_reg;

    // Configuration
    logic        mode_reg;
    logic [30:0] lr_reg, mom_reg, etp_reg, etm_reg, smin_reg, smax_reg;

    // Transaction payload
    logic [1:0]         cmd_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic signed [31:0] value_reg, g_reg;
    logic               last_reg;

    // Working registers
    logic signed [31:0] w_reg, step_reg, lgrad_reg, err_reg, tmp_reg;
    logic signed [31:0] res_sum_reg, res_nw_reg, res_err_reg;
    logic               res_kind_reg;
    logic               out_kind_reg;
    logic signed [31:0] out_sum_reg, out_nw_reg, out_err_reg;

    // Memories
    logic signed [31:0] wmem [DEPTH];
    logic [63:0]        sgmem [DEPTH];
    logic signed [31:0] w_rd_reg;
    logic [63:0]        sg_rd_reg;
    logic               sgv_rd_reg;

    logic [ENTRY_W-1:0] rd_addr, w_addr;
    logic               w_we;
    logic signed [31:0] w_wdata;
    logic               sg_we;

    logic               accept, in_range, out_free, is_bias;
    logic signed [31:0] mul_a, mul_b, q;
    logic signed [63:0] prod;
    logic               gi_zero, lg_zero, same_sign, flip_sign;
    logic signed [31:0] nw_calc, step_calc, ngrad_calc, diff_gm;
    logic signed [32:0] corr;
    logic signed [63:0] acc_rnd;

    assign accept   = s_valid && s_ready;
    assign in_range = (s_entry <= BIAS_IDX);
    assign out_free = !m_valid_reg || m_ready;
    assign is_bias  = (entry_reg == BIAS_IDX);
    assign q        = qround(prod);

    assign m_valid      = m_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_sum_out    = out_sum_reg;
    assign m_new_weight = out_nw_reg;
    assign m_error_term = out_err_reg;

    nrbt_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod)
    );

    // Sign relation between the stored gradient and the new one (tmp_reg).
    assign gi_zero   = (tmp_reg == 32'sd0);
    assign lg_zero   = (lgrad_reg == 32'sd0);
    assign same_sign = !gi_zero && !lg_zero && (tmp_reg[31] == lgrad_reg[31]);
    assign flip_sign = !gi_zero && !lg_zero && (tmp_reg[31] != lgrad_reg[31]);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_cmd == CMD_FWD)) begin
                    state_next = S_READ;
                end else if (accept && (s_cmd == CMD_LEARN) && in_range) begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = (cmd_reg == CMD_FWD) ? S_FACC : S_L1;
            S_FACC:  state_next = last_reg ? S_FBIAS : S_IDLE;
            S_FBIAS: state_next = S_FSUM;
            S_FSUM:  state_next = S_OUT;
            S_L1:    state_next = S_L2;
            S_L2:    state_next = S_L3;
            S_L3:    state_next = S_L4;
            S_L4:    state_next = S_L5;
            S_L5:    state_next = S_OUT;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs: handshake, memory ports and multiplier operands
    always_comb begin
        s_ready = 1'b0;
        rd_addr = in_range ? s_entry : '0;
        w_we    = 1'b0;
        w_addr  = s_entry;
        w_wdata = s_value;
        sg_we   = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                w_we    = s_valid && (s_cmd == CMD_LOAD) && in_range;
            end
            S_READ: begin
                if (cmd_reg == CMD_FWD) begin
                    // The bias and entries beyond the table contribute nothing,
                    // so the weight read for them is never used.
                    if (entry_reg < BIAS_IDX) begin
                        mul_a = value_reg;
                        mul_b = w_rd_reg;
                    end
                end else begin
                    mul_a = g_reg;
                    mul_b = w_rd_reg;
                end
            end
            S_FACC: begin
                rd_addr = BIAS_IDX;
            end
            S_L1: begin
                mul_a = mode_reg ? g_reg : $signed({1'b0, lr_reg});
                mul_b = mode_reg ? value_reg : g_reg;
            end
            S_L3: begin
                if (mode_reg) begin
                    mul_a = step_reg;
                    mul_b = same_sign ? $signed({1'b0, etp_reg}) : $signed({1'b0, etm_reg});
                end else begin
                    mul_a = tmp_reg;
                    mul_b = value_reg;
                end
            end
            S_L4: begin
                mul_a = $signed({1'b0, mom_reg});
                mul_b = w_reg;
            end
            S_L5: begin
                w_we    = 1'b1;
                w_addr  = entry_reg;
                w_wdata = nw_calc;
                sg_we   = mode_reg;
            end
            default: begin
            end
        endcase
    end

    // Final weight, step and gradient of a learn transaction
    always_comb begin
        diff_gm    = sat33({tmp_reg[31], tmp_reg} - {q[31], q});
        corr       = '0;
        ngrad_calc = flip_sign ? 32'sd0 : tmp_reg;
        step_calc  = q;
        if (same_sign) begin
            if (q > $signed({1'b0, smax_reg})) begin
                step_calc = $signed({1'b0, smax_reg});
            end
        end else if (flip_sign) begin
            if (q < $signed({1'b0, smin_reg})) begin
                step_calc = $signed({1'b0, smin_reg});
            end
        end else begin
            step_calc = step_reg;
        end
        if (!flip_sign && !gi_zero) begin
            corr = tmp_reg[31] ? {step_reg[31], step_reg} : -{step_reg[31], step_reg};
        end
        if (mode_reg) begin
            nw_calc = sat33({w_reg[31], w_reg} + corr);
        end else begin
            nw_calc = sat33({w_reg[31], w_reg} - {diff_gm[31], diff_gm});
        end
    end

    assign acc_rnd = sat_add64(acc_reg, 64'sd8388608);

    // Memories
    always_ff @(posedge aclk) begin
        if (w_we) begin
            wmem[w_addr] <= w_wdata;
        end
        if (sg_we) begin
            sgmem[entry_reg] <= {step_reg, ngrad_calc};
        end
        w_rd_reg   <= wmem[rd_addr];
        sg_rd_reg  <= sgmem[rd_addr];
        sgv_rd_reg <= sgv_reg[rd_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            sgv_reg     <= '0;
            mode_reg    <= 1'b0;
            lr_reg      <= 31'd18790482;
            mom_reg     <= 31'd0;
            etp_reg     <= 31'd20132659;
            etm_reg     <= 31'd15938355;
            smin_reg    <= 31'd17;
            smax_reg    <= 31'd838860800;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_FACC) begin
                acc_reg <= sat_add64(acc_reg, prod);
            end else if (state_reg == S_FBIAS) begin
                acc_reg <= sat_add64(acc_reg, {{8{w_rd_reg[31]}}, w_rd_reg, 24'd0});
            end else if (state_reg == S_FSUM) begin
                acc_reg <= '0;
            end
            if (sg_we) begin
                sgv_reg[entry_reg] <= 1'b1;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_MODE: mode_reg <= cfg_wdata[0];
                    CFG_LR:   lr_reg   <= cfg_wdata;
                    CFG_MOM:  mom_reg  <= cfg_wdata;
                    CFG_ETP:  etp_reg  <= cfg_wdata;
                    CFG_ETM:  etm_reg  <= cfg_wdata;
                    CFG_SMIN: smin_reg <= cfg_wdata;
                    CFG_SMAX: smax_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= s_cmd;
            entry_reg <= s_entry;
            value_reg <= s_value;
            g_reg     <= s_grad_in;
            last_reg  <= s_last;
        end
        case (state_reg)
            S_READ: begin
                w_reg     <= w_rd_reg;
                step_reg  <= sgv_rd_reg ? $signed(sg_rd_reg[63:32]) : 32'sd0;
                lgrad_reg <= sgv_rd_reg ? $signed(sg_rd_reg[31:0]) : 32'sd0;
            end
            S_L1: begin
                err_reg <= is_bias ? 32'sd0 : q;
            end
            S_L2: begin
                tmp_reg <= (mode_reg && is_bias) ? g_reg : q;
            end
            S_L4: begin
                if (mode_reg) begin
                    step_reg <= step_calc;
                end else if (!is_bias) begin
                    tmp_reg <= q;
                end
            end
            S_L5: begin
                res_kind_reg <= KIND_LEARN;
                res_sum_reg  <= '0;
                res_nw_reg   <= nw_calc;
                res_err_reg  <= err_reg;
            end
            S_FSUM: begin
                res_kind_reg <= KIND_SUM;
                res_sum_reg  <= sat41({acc_rnd[63], acc_rnd[63:24]});
                res_nw_reg   <= '0;
                res_err_reg  <= '0;
            end
            S_OUT: begin
                if (out_free) begin
                    out_kind_reg <= res_kind_reg;
                    out_sum_reg  <= res_sum_reg;
                    out_nw_reg   <= res_nw_reg;
                    out_err_reg  <= res_err_reg;
                end
            end
            default: begin
            end
        endcase
    end

    `NRBT_ASSERT_NEXT(a_fwd_reads, accept && (s_cmd == CMD_FWD), state_reg == S_READ, "no read")
    `NRBT_ASSERT_NEXT(a_acc_cleared, state_reg == S_FSUM, acc_reg == 64'sd0, "acc not cleared")
    `NRBT_ASSERT_SAME(a_wr_place, w_we, (state_reg == S_IDLE) || (state_reg == S_L5), "bad write")
    `NRBT_ASSERT_NEXT(a_learn_out, state_reg == S_L5, state_reg == S_OUT, "learn not output")

endmodule
